### rtl/rcf_pkg.sv
`timescale 1ns / 1ps

package rcf_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 64;

    localparam int SEQ_BITS  = 64;
    localparam int TIME_BITS = 32;
    localparam int TTL_BITS  = 16;
    localparam int LIVE_BITS = 7;

    localparam logic [TTL_BITS-1:0] TTL_RESET = 16'd60;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_DUP    = 2'd1,
        VERDICT_FULL   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [63:0]          sender_tag;
        logic [SEQ_BITS-1:0]  sequence_number;
        logic [TIME_BITS-1:0] current_time;
    } req_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [LIVE_BITS-1:0] live_entries;
    } rsp_t;

endpackage

### rtl/rcf_entry_ram.sv
`timescale 1ns / 1ps

module rcf_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 161,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/replay_cache_filter_top.sv
`timescale 1ns / 1ps

// Anti-replay filter with time-to-live expiry. All slots live in one
// single-port-read, single-port-write memory. After reset the block runs a
// clearing pass over all CAPACITY slots with busy high; configuration
// writes are taken during that time. A request is accepted when start is
// high and busy is low. The block then sweeps every slot through the memory
// read port, one slot per cycle: it frees expired entries, looks for a
// duplicate and picks the lowest free slot. The commit state follows the
// sweep, and the result appears for exactly one cycle with done high in the
// cycle after the commit, during which busy is already low. Busy stays high
// through the sweep and the commit, so a new request is taken only once the
// last one is through. The result cannot be stalled, so it must be captured
// while done is high.

module replay_cache_filter_top #(
    parameter int CAPACITY = rcf_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = rcf_pkg::TAG_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rcf_pkg::req_t         request,
    output logic                  done,
    output rcf_pkg::rsp_t         result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [rcf_pkg::TTL_BITS-1:0] cfg_data
);

    import rcf_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 1 + TAG_BITS + SEQ_BITS + TIME_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic [IW:0]           idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  dup_reg, dup_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TTL_BITS-1:0]   ttl_reg;
    logic                  done_reg, done_next;
    rsp_t                  result_reg, result_next;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;
    logic [EW-1:0]         rd_data;

    logic                  ent_valid;
    logic [TAG_BITS-1:0]   ent_tag;
    logic [SEQ_BITS-1:0]   ent_seq;
    logic [TIME_BITS-1:0]  ent_stamp;
    logic [TIME_BITS-1:0]  age;
    logic                  expired;
    logic                  live;
    logic                  hit;
    logic                  sweep_end;

    rcf_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign ent_valid = rd_data[EW-1];
    assign ent_tag   = rd_data[EW-2 -: TAG_BITS];
    assign ent_seq   = rd_data[TIME_BITS +: SEQ_BITS];
    assign ent_stamp = rd_data[TIME_BITS-1:0];

    // Modular age; only an age strictly above the TTL expires the entry.
    assign age       = now_reg - ent_stamp;
    assign expired   = ent_valid && (age > {{(TIME_BITS-TTL_BITS){1'b0}}, ttl_reg});
    assign live      = ent_valid && !expired;
    assign hit       = live && (ent_tag == tag_reg) && (ent_seq == seq_reg);
    assign sweep_end = (idx_reg == (IW+1)'(CAPACITY));

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        dup_next      = dup_reg;
        found_next    = found_reg;
        free_idx_next = free_idx_reg;
        count_next    = count_reg;
        tag_next      = tag_reg;
        seq_next      = seq_reg;
        now_next      = now_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data       = {1'b0, rd_data[EW-2:0]};

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IW-1:0];
                wr_data = '0;
                if (idx_reg == (IW+1)'(CAPACITY - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    dup_next   = 1'b0;
                    found_next = 1'b0;
                    tag_next   = request.sender_tag[TAG_BITS-1:0];
                    seq_next   = request.sequence_number;
                    now_next   = request.current_time;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                // Read of slot idx is issued while slot idx-1 is processed.
                pend_next     = !sweep_end;
                pend_idx_next = idx_reg[IW-1:0];
                if (!sweep_end)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (expired)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    if (hit)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!live && !found_reg)
                    begin
                        found_next    = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                if (sweep_end)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                done_next = 1'b1;
                if (dup_reg)
                begin
                    result_next.verdict      = VERDICT_DUP;
                    result_next.live_entries = LIVE_BITS'(count_reg);
                end
                else if (!found_reg)
                begin
                    result_next.verdict      = VERDICT_FULL;
                    result_next.live_entries = LIVE_BITS'(count_reg);
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = free_idx_reg;
                    wr_data    = {1'b1, tag_reg, seq_reg, now_reg};
                    count_next = CW'(count_reg + 1'b1);
                    result_next.verdict      = VERDICT_ACCEPT;
                    result_next.live_entries = LIVE_BITS'(count_next);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            dup_reg      <= 1'b0;
            found_reg    <= 1'b0;
            free_idx_reg <= '0;
            count_reg    <= '0;
            tag_reg      <= '0;
            seq_reg      <= '0;
            now_reg      <= '0;
            ttl_reg      <= TTL_RESET;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            dup_reg      <= dup_next;
            found_reg    <= found_next;
            free_idx_reg <= free_idx_next;
            count_reg    <= count_next;
            tag_reg      <= tag_next;
            seq_reg      <= seq_next;
            now_reg      <= now_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                ttl_reg <= cfg_data;
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_COMMIT))
        else $error("result strobe without a commit cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("live count exceeds capacity");

    a_start_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_SWEEP))
        else $error("accepted request did not start a sweep");

    a_accept_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.verdict == VERDICT_ACCEPT) |-> (count_reg != '0))
        else $error("accepted request left the table empty");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rcf_pkg::*;

    localparam int SLOTS        = CAPACITY_DEF;
    localparam int TAG_WIDTH    = TAG_BITS_DEF;
    localparam logic [63:0] TAG_MASK = {64{1'b1}} >> (64 - TAG_WIDTH);
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int POOL_DEPTH   = 16;

    typedef enum int {SCENE_CHURN, SCENE_FILL, SCENE_WILD} scene_t;

    typedef struct {
        logic                 is_cfg;
        logic [TTL_BITS-1:0]  ttl;
        req_t                 item;
        verdict_t             verdict;
        logic [LIVE_BITS-1:0] live;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                request;
    logic                done;
    rsp_t                result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TTL_BITS-1:0] cfg_data;

    // Predicted copy of the cache.
    logic                 slot_live  [SLOTS];
    logic [63:0]          slot_tag   [SLOTS];
    logic [SEQ_BITS-1:0]  slot_seq   [SLOTS];
    logic [TIME_BITS-1:0] slot_stamp [SLOTS];
    int                   live_count;
    logic [TTL_BITS-1:0]  ttl_now;

    rsp_t      expected_verdicts[$];
    plan_row_t plan[$];
    logic      pinned_now;
    rsp_t      pinned_rsp;
    logic      steady;
    int        error_count;
    int        cycle_count;

    replay_cache_filter_top #(
        .CAPACITY(SLOTS),
        .TAG_BITS(TAG_WIDTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Expire old entries, then look for a duplicate and the lowest free slot.
    function automatic rsp_t screen_request(input req_t r);
        logic [63:0]          tag_key;
        logic [TIME_BITS-1:0] age;
        logic                 dup_hit;
        logic                 have_free;
        int                   free_idx;
        rsp_t                 res;
        tag_key   = r.sender_tag & TAG_MASK;
        dup_hit   = 1'b0;
        have_free = 1'b0;
        free_idx  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i])
            begin
                age = r.current_time - slot_stamp[i];
                if (age > {16'd0, ttl_now})
                begin
                    slot_live[i] = 1'b0;
                    if (live_count > 0)
                        live_count--;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i])
            begin
                if (slot_tag[i] == tag_key && slot_seq[i] == r.sequence_number)
                    dup_hit = 1'b1;
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_idx  = i;
            end
        end
        if (dup_hit)
            res.verdict = VERDICT_DUP;
        else if (!have_free)
            res.verdict = VERDICT_FULL;
        else
        begin
            res.verdict          = VERDICT_ACCEPT;
            slot_live[free_idx]  = 1'b1;
            slot_tag[free_idx]   = tag_key;
            slot_seq[free_idx]   = r.sequence_number;
            slot_stamp[free_idx] = r.current_time;
            live_count++;
        end
        res.live_entries = live_count[LIVE_BITS-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        rsp_t want;
        rsp_t calc;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result: verdict %0d live_entries %0d",
                           result.verdict, result.live_entries);
                    error_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result.verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d",
                               want.verdict, result.verdict);
                        error_count++;
                    end
                    if (result.live_entries !== want.live_entries)
                    begin
                        $error("live_entries: expected %0d, got %0d",
                               want.live_entries, result.live_entries);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                ttl_now = cfg_data;
            if (start && !busy)
            begin
                calc = screen_request(request);
                if (pinned_now)
                    expected_verdicts.push_back(pinned_rsp);
                else
                    expected_verdicts.push_back(calc);
            end
        end
    end

    task automatic send_request(input req_t r, input logic pinned, input rsp_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        // Outside steady runs, half of the time the gap is counted from the end of the previous request.
        if (!steady && $urandom_range(0, 1) == 1)
        begin
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
        @(negedge clk);
        pinned_now = pinned;
        pinned_rsp = want;
        request   <= r;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic write_ttl(input logic [TTL_BITS-1:0] value);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat ($urandom_range(0, 5)) @(negedge clk);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_item(input logic [63:0] tag, input logic [63:0] seq,
                                      input logic [31:0] stamp, input verdict_t v,
                                      input logic [LIVE_BITS-1:0] live);
        plan_row_t row;
        row.is_cfg                = 1'b0;
        row.ttl                   = '0;
        row.item.sender_tag       = tag;
        row.item.sequence_number  = seq;
        row.item.current_time     = stamp;
        row.verdict               = v;
        row.live                  = live;
        plan.push_back(row);
    endfunction

    function automatic void plan_ttl(input logic [TTL_BITS-1:0] value);
        plan_row_t row;
        row.is_cfg  = 1'b1;
        row.ttl     = value;
        row.item    = '0;
        row.verdict = VERDICT_ACCEPT;
        row.live    = '0;
        plan.push_back(row);
    endfunction

    initial
    begin : stimulus
        req_t                 item;
        req_t                 pick;
        req_t                 recent[POOL_DEPTH];
        int                   recent_n;
        int                   recent_wr;
        int                   random_sent;
        int                   run_len;
        int                   choice;
        int                   fresh_cut;
        scene_t               scene;
        logic [TTL_BITS-1:0]  ttl_pick;
        logic [TIME_BITS-1:0] now_time;
        rsp_t                 want;

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        pinned_now  = 1'b0;
        pinned_rsp  = '0;
        steady      = 1'b0;
        error_count = 0;
        cycle_count = 0;
        live_count  = 0;
        ttl_now     = TTL_RESET;
        recent_n    = 0;
        recent_wr   = 0;
        random_sent = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_tag[i]   = '0;
            slot_seq[i]   = '0;
            slot_stamp[i] = '0;
        end

        // Directed part, starting with the reset lifetime of 60 seconds.
        plan_item(64'd0, 64'd0, 32'd100, VERDICT_ACCEPT, 7'd1);
        plan_item(64'd0, 64'd0, 32'd100, VERDICT_DUP, 7'd1);
        plan_item({64{1'b1}}, {64{1'b1}}, 32'd100, VERDICT_ACCEPT, 7'd2);
        // An age equal to the lifetime keeps the entry.
        plan_item({64{1'b1}}, 64'd0, 32'd160, VERDICT_ACCEPT, 7'd3);
        plan_item(64'd0, 64'd0, 32'd160, VERDICT_DUP, 7'd3);
        plan_item(64'd5, 64'd5, 32'd161, VERDICT_ACCEPT, 7'd2);
        // The repeat of an expired request is accepted again.
        plan_item(64'd0, 64'd0, 32'd161, VERDICT_ACCEPT, 7'd3);
        // Time going backwards expires everything.
        plan_item(64'd9, 64'd9, 32'd50, VERDICT_ACCEPT, 7'd1);
        plan_item(64'd1, 64'd2, 32'hFFFF_FFF0, VERDICT_ACCEPT, 7'd1);
        // The age is taken across the wrap of the time counter.
        plan_item(64'd1, 64'd2, 32'h0000_0010, VERDICT_DUP, 7'd1);
        plan_ttl(16'd0);
        plan_item(64'd3, 64'd3, 32'd0, VERDICT_ACCEPT, 7'd1);
        plan_item(64'd3, 64'd3, 32'd0, VERDICT_DUP, 7'd1);
        plan_item(64'd3, 64'd3, 32'd1, VERDICT_ACCEPT, 7'd1);
        plan_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF,
                  VERDICT_ACCEPT, 7'd1);
        plan_ttl(16'hFFFF);
        plan_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'h0000_FFFE,
                  VERDICT_DUP, 7'd1);
        plan_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'h0000_FFFF,
                  VERDICT_ACCEPT, 7'd1);
        plan_item(64'd0, 64'h8000_0000_0000_0000, 32'h0000_FFFF, VERDICT_ACCEPT, 7'd2);
        plan_item(64'h8000_0000_0000_0000, 64'd0, 32'h0000_FFFF, VERDICT_ACCEPT, 7'd3);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_ttl(plan[i].ttl);
            else
            begin
                want.verdict      = plan[i].verdict;
                want.live_entries = plan[i].live;
                send_request(plan[i].item, 1'b1, want);
            end
        end

        // Random part: churn with short lifetimes, filling runs that hit a full
        // table, and runs with wild times and lifetimes.
        while (random_sent < RANDOM_ITEMS)
        begin
            scene  = scene_t'($urandom_range(0, 2));
            steady = ($urandom_range(0, 3) == 0);
            case (scene)
                SCENE_CHURN: ttl_pick = TTL_BITS'($urandom_range(0, 40));
                SCENE_FILL:  ttl_pick = ($urandom_range(0, 1) == 1)
                                        ? 16'hFFFF
                                        : TTL_BITS'($urandom_range(200, 65535));
                default:     ttl_pick = TTL_BITS'($urandom_range(0, 65535));
            endcase
            write_ttl(ttl_pick);
            if ($urandom_range(0, 3) == 0)
                now_time = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else
                now_time = $urandom;
            run_len   = $urandom_range(40, 160);
            fresh_cut = (scene == SCENE_FILL) ? 90 : 62;
            repeat (run_len)
            begin
                case (scene)
                    SCENE_CHURN:
                    begin
                        if ($urandom_range(0, 99) < 4)
                            now_time = now_time - $urandom_range(1, 100);
                        else
                            now_time = now_time + $urandom_range(0, ttl_pick / 4 + 2);
                    end
                    SCENE_FILL:
                        now_time = now_time + $urandom_range(0, 1);
                    default:
                    begin
                        if ($urandom_range(0, 99) < 20)
                            now_time = $urandom;
                        else
                            now_time = now_time + $urandom_range(0, 3);
                    end
                endcase
                item.sender_tag      = {$urandom, $urandom};
                item.sequence_number = {$urandom, $urandom};
                choice = $urandom_range(0, 99);
                if (recent_n > 0 && choice >= fresh_cut)
                begin
                    pick = recent[$urandom_range(0, recent_n - 1)];
                    choice = $urandom_range(0, 9);
                    if (choice < 8)
                        item.sender_tag = pick.sender_tag;
                    if (choice < 6 || choice >= 8)
                        item.sequence_number = pick.sequence_number;
                end
                item.current_time = now_time;
                send_request(item, 1'b0, '0);
                recent[recent_wr] = item;
                recent_wr = (recent_wr + 1) % POOL_DEPTH;
                if (recent_n < POOL_DEPTH)
                    recent_n++;
                random_sent++;
            end
        end

        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/rcf_pkg.sv
rtl/rcf_entry_ram.sv
rtl/replay_cache_filter_top.sv
tb/tb_top.sv
